>>> hdl/phsc_pkg.sv
// ----------------------------------------------------------------------------
// phsc_pkg
// shared types and constants of the prefix hash substring compare block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phsc_pkg;

	localparam int VALUE_W  = 30;
	localparam int INDEX_W  = 10;
	localparam int SYMBOL_W = 8;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	typedef logic [VALUE_W-1:0] value_t;

	localparam value_t HASH_MOD   = 30'd1000000007;
	localparam value_t BASE_RESET = 30'd29;
	localparam logic [SYMBOL_W-1:0] SYMBOL_OFFSET = 8'd96;

	// barrett factor floor(2^60 / modulus)
	localparam logic [63:0] BARRETT_MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
	localparam logic [30:0] BARRETT_MU      = BARRETT_MU_FULL[30:0];

	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic pre_rd;
		logic pre_wr;
		logic pwr_rd;
		logic pwr_wr;
	} store_ctl_t;

endpackage

>>> hdl/phsc_modmul.sv
// ----------------------------------------------------------------------------
// phsc_modmul
// pipelined 30 x 30 bit multiply reduced modulo 1000000007 (barrett),
// six register stages, one new operand pair per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phsc_modmul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  phsc_pkg::value_t in_a,
	input  phsc_pkg::value_t in_b,
	output logic            out_valid,
	output phsc_pkg::value_t out_value
);

	localparam logic [31:0] MOD1 = {2'b00, phsc_pkg::HASH_MOD};
	localparam logic [31:0] MOD2 = {1'b0, phsc_pkg::HASH_MOD, 1'b0};
	localparam logic [31:0] MOD3 = MOD1 + MOD2;

	logic v_s0, v_s1, v_s2, v_s3, v_s4, v_s5;

	phsc_pkg::value_t a_s0, b_s0;
	logic [59:0] prod_s1;
	logic [61:0] q2_s2;
	logic [31:0] plow_s2, plow_s3;
	logic [31:0] qm_s3;
	logic [31:0] rem_s4;
	phsc_pkg::value_t out_s5;

	logic [60:0] qm_full;
	logic [31:0] rem_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s0 <= in_valid;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign qm_full = q2_s2[61:31] * phsc_pkg::HASH_MOD;

	always_comb begin
		if (rem_s4 >= MOD2) begin
			rem_fix = rem_s4 - MOD2;
		end else if (rem_s4 >= MOD1) begin
			rem_fix = rem_s4 - MOD1;
		end else begin
			rem_fix = rem_s4;
		end
	end

	always_ff @(posedge clk) begin
		a_s0    <= in_a;
		b_s0    <= in_b;
		prod_s1 <= a_s0 * b_s0;
		q2_s2   <= prod_s1[59:29] * phsc_pkg::BARRETT_MU;
		plow_s2 <= prod_s1[31:0];
		qm_s3   <= qm_full[31:0];
		plow_s3 <= plow_s2;
		rem_s4  <= plow_s3 - qm_s3;
		out_s5  <= rem_fix[29:0];
	end

	assign out_valid = v_s5;
	assign out_value = out_s5;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (rem_s4 < MOD3))
		else $error("barrett remainder out of range");

	a_out_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_value < phsc_pkg::HASH_MOD))
		else $error("modular product not reduced");

endmodule

>>> hdl/phsc_store.sv
// ----------------------------------------------------------------------------
// phsc_store
// prefix hash memory and base power memory, one write and two registered
// reads each; prefix entry zero always reads as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phsc_store #(
	parameter int MAX_LENGTH = 1024,
	localparam int LW = $clog2(MAX_LENGTH + 1),
	localparam int PW = $clog2(MAX_LENGTH)
) (
	input  logic                 clk,
	input  phsc_pkg::store_ctl_t ctl,
	input  logic [LW-1:0]        pre_raddr0,
	input  logic [LW-1:0]        pre_raddr1,
	input  logic [LW-1:0]        pre_waddr,
	input  phsc_pkg::value_t     pre_wdata,
	output phsc_pkg::value_t     pre_rdata0,
	output phsc_pkg::value_t     pre_rdata1,
	input  logic [PW-1:0]        pwr_raddr0,
	input  logic [PW-1:0]        pwr_raddr1,
	input  logic [PW-1:0]        pwr_waddr,
	input  phsc_pkg::value_t     pwr_wdata,
	output phsc_pkg::value_t     pwr_rdata0,
	output phsc_pkg::value_t     pwr_rdata1
);

	phsc_pkg::value_t pre_mem [MAX_LENGTH + 1];
	phsc_pkg::value_t pwr_mem [MAX_LENGTH];

	phsc_pkg::value_t pre_rd0_q, pre_rd1_q;
	phsc_pkg::value_t pwr_rd0_q, pwr_rd1_q;
	logic             pre_zero0_q, pre_zero1_q;

	always_ff @(posedge clk) begin
		if (ctl.pre_wr) begin
			pre_mem[pre_waddr] <= pre_wdata;
		end
		if (ctl.pre_rd) begin
			pre_rd0_q   <= pre_mem[pre_raddr0];
			pre_rd1_q   <= pre_mem[pre_raddr1];
			pre_zero0_q <= (pre_raddr0 == '0);
			pre_zero1_q <= (pre_raddr1 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pwr_wr) begin
			pwr_mem[pwr_waddr] <= pwr_wdata;
		end
		if (ctl.pwr_rd) begin
			pwr_rd0_q <= pwr_mem[pwr_raddr0];
			pwr_rd1_q <= pwr_mem[pwr_raddr1];
		end
	end

	// empty prefix hash is zero and never written
	assign pre_rdata0 = pre_zero0_q ? '0 : pre_rd0_q;
	assign pre_rdata1 = pre_zero1_q ? '0 : pre_rd1_q;
	assign pwr_rdata0 = pwr_rd0_q;
	assign pwr_rdata1 = pwr_rd1_q;

endmodule

>>> hdl/prefix_hash_substring_compare.sv
// ----------------------------------------------------------------------------
// prefix_hash_substring_compare
// polynomial prefix hashes of a string mod 1000000007 with substring compare
// one item at a time: in_ready is high only in idle, so a new item is taken only
//   after the previous result has been loaded into the output register; append
//   and query each pass two products through the six-stage modular multiplier
// reset: arst_n clears length, base power to 1 and hash_base to 29; memories
//   are not cleared, items are taken right after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_hash_substring_compare #(
	parameter int MAX_LENGTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  phsc_pkg::value_t                 cfg_write_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [phsc_pkg::OP_W-1:0]        op,
	input  logic [phsc_pkg::SYMBOL_W-1:0]    symbol,
	input  logic [phsc_pkg::INDEX_W-1:0]     first_start,
	input  logic [phsc_pkg::INDEX_W-1:0]     first_end,
	input  logic [phsc_pkg::INDEX_W-1:0]     second_start,
	input  logic [phsc_pkg::INDEX_W-1:0]     second_end,
	output logic                             out_valid,
	input  logic                             out_ready,
	output phsc_pkg::value_t                 first_value,
	output phsc_pkg::value_t                 second_value,
	output logic                             equal,
	output logic [phsc_pkg::STATUS_W-1:0]    status
);

	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int PW = $clog2(MAX_LENGTH);
	localparam int CW = (LW > phsc_pkg::INDEX_W) ? LW : phsc_pkg::INDEX_W + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_APP   = 3'd2;
	localparam logic [2:0] S_QRY1  = 3'd3;
	localparam logic [2:0] S_QRY2  = 3'd4;
	localparam logic [2:0] S_WAIT  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	function automatic phsc_pkg::value_t sub_mod(phsc_pkg::value_t hi, phsc_pkg::value_t lo);
		logic [phsc_pkg::VALUE_W:0] d;
		d = {1'b0, hi} - {1'b0, lo};
		return d[phsc_pkg::VALUE_W] ? (d[phsc_pkg::VALUE_W-1:0] + phsc_pkg::HASH_MOD)
			: d[phsc_pkg::VALUE_W-1:0];
	endfunction

	function automatic phsc_pkg::value_t add_mod(phsc_pkg::value_t x, phsc_pkg::value_t y);
		logic [phsc_pkg::VALUE_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, phsc_pkg::HASH_MOD}) begin
			s = s - {1'b0, phsc_pkg::HASH_MOD};
		end
		return s[phsc_pkg::VALUE_W-1:0];
	endfunction

	logic [2:0] state_q, state_d;

	phsc_pkg::value_t hash_base_q;
	phsc_pkg::value_t np_q;
	logic [LW-1:0]    len_q;

	logic [phsc_pkg::OP_W-1:0]     op_q;
	logic [phsc_pkg::SYMBOL_W-1:0] sym_q;
	logic [phsc_pkg::INDEX_W-1:0]  fs_q, fe_q, ss_q, se_q;
	logic [phsc_pkg::STATUS_W-1:0] res_status_q;
	logic                          len_eq_q;
	logic                          res_cnt_q;
	phsc_pkg::value_t              r0_q, r1_q;

	logic                          out_valid_q;
	phsc_pkg::value_t              first_value_q, second_value_q;
	logic                          equal_q;
	logic [phsc_pkg::STATUS_W-1:0] out_status_q;

	logic [CW-1:0] fs_c, fe_c, ss_c, se_c, len_c, fe_p1, se_p1;
	logic          bad_range, full, done_go, app_ok, qry_ok;
	phsc_pkg::value_t sym_val, sym_ext;

	logic             mm_in_valid, mm_out_valid;
	phsc_pkg::value_t mm_a, mm_b, mm_out;

	phsc_pkg::store_ctl_t st_ctl;
	logic [LW-1:0]    pre_raddr0, pre_raddr1, pre_waddr;
	logic [PW-1:0]    pwr_raddr0, pwr_raddr1, pwr_waddr;
	phsc_pkg::value_t pre_wdata, pre_rdata0, pre_rdata1, pwr_rdata0, pwr_rdata1;

	// decode of the held transaction
	assign fs_c  = CW'(fs_q);
	assign fe_c  = CW'(fe_q);
	assign ss_c  = CW'(ss_q);
	assign se_c  = CW'(se_q);
	assign len_c = CW'(len_q);
	assign fe_p1 = fe_c + CW'(1);
	assign se_p1 = se_c + CW'(1);

	assign bad_range = (fs_c > fe_c) || (ss_c > se_c) || (fe_c >= len_c) || (se_c >= len_c);
	assign full      = (len_q == LW'(MAX_LENGTH));

	assign sym_ext = {{(phsc_pkg::VALUE_W - phsc_pkg::SYMBOL_W){1'b0}}, sym_q};
	assign sym_val = (sym_q >= phsc_pkg::SYMBOL_OFFSET)
		? sym_ext - phsc_pkg::value_t'(phsc_pkg::SYMBOL_OFFSET)
		: sym_ext + phsc_pkg::HASH_MOD - phsc_pkg::value_t'(phsc_pkg::SYMBOL_OFFSET);

	assign done_go = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign app_ok  = (op_q == phsc_pkg::OP_APPEND) && (res_status_q == phsc_pkg::STATUS_OK);
	assign qry_ok  = (op_q == phsc_pkg::OP_QUERY) && (res_status_q == phsc_pkg::STATUS_OK);

	assign in_ready = (state_q == S_IDLE);

	// multiplier issue
	always_comb begin
		mm_in_valid = 1'b0;
		mm_a        = '0;
		mm_b        = '0;
		case (state_q)
			S_CHECK: begin
				if (op_q == phsc_pkg::OP_APPEND && !full) begin
					mm_in_valid = 1'b1;
					mm_a        = sym_val;
					mm_b        = np_q;
				end
			end
			S_APP: begin
				mm_in_valid = 1'b1;
				mm_a        = np_q;
				mm_b        = hash_base_q;
			end
			S_QRY1: begin
				mm_in_valid = 1'b1;
				mm_a        = pwr_rdata0;
				mm_b        = sub_mod(pre_rdata0, pre_rdata1);
			end
			S_QRY2: begin
				mm_in_valid = 1'b1;
				mm_a        = pwr_rdata1;
				mm_b        = sub_mod(pre_rdata0, pre_rdata1);
			end
			default: begin
				mm_in_valid = 1'b0;
			end
		endcase
	end

	// memory access
	always_comb begin
		st_ctl.pre_rd = (state_q == S_CHECK) || (state_q == S_QRY1);
		st_ctl.pwr_rd = (state_q == S_CHECK);
		st_ctl.pre_wr = done_go && app_ok;
		st_ctl.pwr_wr = done_go && app_ok;
	end

	assign pre_raddr0 = (state_q == S_CHECK)
		? ((op_q == phsc_pkg::OP_APPEND) ? len_q : fe_p1[LW-1:0])
		: se_p1[LW-1:0];
	assign pre_raddr1 = (state_q == S_CHECK) ? fs_c[LW-1:0] : ss_c[LW-1:0];
	assign pwr_raddr0 = ss_c[PW-1:0];
	assign pwr_raddr1 = fs_c[PW-1:0];
	assign pre_waddr  = len_q + LW'(1);
	assign pre_wdata  = add_mod(pre_rdata0, r0_q);
	assign pwr_waddr  = len_q[PW-1:0];

	phsc_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mm_in_valid),
		.in_a      (mm_a),
		.in_b      (mm_b),
		.out_valid (mm_out_valid),
		.out_value (mm_out)
	);

	phsc_store #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_store (
		.clk        (clk),
		.ctl        (st_ctl),
		.pre_raddr0 (pre_raddr0),
		.pre_raddr1 (pre_raddr1),
		.pre_waddr  (pre_waddr),
		.pre_wdata  (pre_wdata),
		.pre_rdata0 (pre_rdata0),
		.pre_rdata1 (pre_rdata1),
		.pwr_raddr0 (pwr_raddr0),
		.pwr_raddr1 (pwr_raddr1),
		.pwr_waddr  (pwr_waddr),
		.pwr_wdata  (np_q),
		.pwr_rdata0 (pwr_rdata0),
		.pwr_rdata1 (pwr_rdata1)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				case (op_q)
					phsc_pkg::OP_APPEND: state_d = full ? S_DONE : S_APP;
					phsc_pkg::OP_QUERY:  state_d = bad_range ? S_DONE : S_QRY1;
					default:             state_d = S_DONE;
				endcase
			end
			S_APP: begin
				state_d = S_WAIT;
			end
			S_QRY1: begin
				state_d = S_QRY2;
			end
			S_QRY2: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (mm_out_valid && res_cnt_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (done_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hash_base_q <= phsc_pkg::BASE_RESET;
			np_q        <= phsc_pkg::value_t'(1);
			len_q       <= '0;
			res_cnt_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				hash_base_q <= cfg_write_data;
			end
			if (state_q == S_CHECK) begin
				res_cnt_q <= 1'b0;
			end else if (state_q == S_WAIT && mm_out_valid) begin
				res_cnt_q <= 1'b1;
			end
			if (done_go) begin
				out_valid_q <= 1'b1;
				if (app_ok) begin
					len_q <= len_q + LW'(1);
					np_q  <= r1_q;
				end else if (op_q == phsc_pkg::OP_CLEAR) begin
					len_q <= '0;
					np_q  <= phsc_pkg::value_t'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= op;
			sym_q <= symbol;
			fs_q  <= first_start;
			fe_q  <= first_end;
			ss_q  <= second_start;
			se_q  <= second_end;
		end
		if (state_q == S_CHECK) begin
			len_eq_q <= ((fe_q - fs_q) == (se_q - ss_q));
			case (op_q)
				phsc_pkg::OP_APPEND:
					res_status_q <= full ? phsc_pkg::STATUS_FULL : phsc_pkg::STATUS_OK;
				phsc_pkg::OP_QUERY:
					res_status_q <= bad_range ? phsc_pkg::STATUS_BAD_RANGE : phsc_pkg::STATUS_OK;
				default:
					res_status_q <= phsc_pkg::STATUS_OK;
			endcase
		end
		if (state_q == S_WAIT && mm_out_valid) begin
			if (res_cnt_q) begin
				r1_q <= mm_out;
			end else begin
				r0_q <= mm_out;
			end
		end
		if (done_go) begin
			first_value_q  <= qry_ok ? r0_q : '0;
			second_value_q <= qry_ok ? r1_q : '0;
			equal_q        <= qry_ok && len_eq_q && (r0_q == r1_q);
			out_status_q   <= res_status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign first_value  = first_value_q;
	assign second_value = second_value_q;
	assign equal        = equal_q;
	assign status       = out_status_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LENGTH))
		else $error("string length above store depth");

	a_mm_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_out_valid |-> (state_q == S_WAIT))
		else $error("product arrived outside wait state");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done_go |=> out_valid)
		else $error("finished transaction not presented");

	a_equal_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && equal) |-> ((first_value == second_value) &&
			(status == phsc_pkg::STATUS_OK)))
		else $error("equal flag without matching values");

endmodule

>>> sim/prefix_hash_substring_compare_tb.sv
// ----------------------------------------------------------------------------
// prefix_hash_substring_compare_tb
// self-checking bench for the prefix hash substring compare block: a directed
// table and random append / query / clear traffic under several hash bases,
// a long-string pass, random bursts and stalls on both sides, and every result
// checked field by field against a typed table reply or an in-bench rolling hash model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_hash_substring_compare_tb;

	typedef longint unsigned wide_t;

	localparam int                         MAX_LEN     = 1024;
	localparam int                         LONG_LEN    = 160;
	localparam wide_t                      MODL        = wide_t'(phsc_pkg::HASH_MOD);
	localparam logic [phsc_pkg::OP_W-1:0]  OP_UNUSED   = 2'd3;
	localparam int                         HOLD_CYCLES = 300;
	localparam int                         CYCLE_LIMIT = 600000;

	typedef struct {
		logic [phsc_pkg::OP_W-1:0]     op;
		logic [phsc_pkg::SYMBOL_W-1:0] sym;
		logic [phsc_pkg::INDEX_W-1:0]  fs;
		logic [phsc_pkg::INDEX_W-1:0]  fe;
		logic [phsc_pkg::INDEX_W-1:0]  ss;
		logic [phsc_pkg::INDEX_W-1:0]  se;
	} hash_txn_t;

	typedef struct {
		phsc_pkg::value_t              v1;
		phsc_pkg::value_t              v2;
		logic                          eq;
		logic [phsc_pkg::STATUS_W-1:0] st;
	} hash_reply_t;

	typedef struct {
		hash_txn_t                     t;
		bit                            typed;
		logic [phsc_pkg::STATUS_W-1:0] st;
	} table_row_t;

	logic                          clk = 1'b1;
	logic                          arst_n = 1'b0;
	logic                          cfg_write_en = 1'b0;
	phsc_pkg::value_t              cfg_write_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [phsc_pkg::OP_W-1:0]     op = '0;
	logic [phsc_pkg::SYMBOL_W-1:0] symbol = '0;
	logic [phsc_pkg::INDEX_W-1:0]  first_start = '0;
	logic [phsc_pkg::INDEX_W-1:0]  first_end = '0;
	logic [phsc_pkg::INDEX_W-1:0]  second_start = '0;
	logic [phsc_pkg::INDEX_W-1:0]  second_end = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	phsc_pkg::value_t              first_value;
	phsc_pkg::value_t              second_value;
	logic                          equal;
	logic [phsc_pkg::STATUS_W-1:0] status;

	// model state
	phsc_pkg::value_t prefix_mem [0:MAX_LEN];
	phsc_pkg::value_t power_mem [0:MAX_LEN-1];
	wide_t            weight;
	wide_t            cur_base;
	int               held_len;

	hash_reply_t pending_replies [$];
	table_row_t  directed_rows [$];
	hash_reply_t want_reply;

	int     mismatch_count = 0;
	int     cycle_count = 0;
	int     burst_left = 0;
	bit     hold_off_req = 1'b0;
	logic [7:0] stall_mask = 8'hFF;
	int     pat_pos = 0;
	int     pat_left = 0;
	int     n_items = 0;
	int     n_results = 0;
	int     n_equal = 0;
	int     n_bad = 0;
	int     n_full = 0;
	int     n_bases = 0;

	prefix_hash_substring_compare #(
		.MAX_LENGTH(MAX_LEN)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.symbol        (symbol),
		.first_start   (first_start),
		.first_end     (first_end),
		.second_start  (second_start),
		.second_end    (second_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.first_value   (first_value),
		.second_value  (second_value),
		.equal         (equal),
		.status        (status)
	);

	always begin
		#10 clk = 1'b0;
		#10 clk = 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic wide_t mod_mul(wide_t x, wide_t y);
		return (x * y) % MODL;
	endfunction

	function automatic hash_reply_t compute_hash_reply(hash_txn_t t);
		hash_reply_t r;
		wide_t       sv;
		wide_t       h1;
		wide_t       h2;
		int          a;
		int          b;
		int          c;
		int          d;
		r.v1 = '0;
		r.v2 = '0;
		r.eq = 1'b0;
		r.st = phsc_pkg::STATUS_OK;
		a = int'(t.fs);
		b = int'(t.fe);
		c = int'(t.ss);
		d = int'(t.se);
		case (t.op)
			phsc_pkg::OP_APPEND: begin
				if (held_len >= MAX_LEN) begin
					r.st = phsc_pkg::STATUS_FULL;
				end else begin
					sv = wide_t'(t.sym);
					if (sv >= wide_t'(phsc_pkg::SYMBOL_OFFSET))
						sv = sv - phsc_pkg::SYMBOL_OFFSET;
					else
						sv = sv + MODL - phsc_pkg::SYMBOL_OFFSET;
					power_mem[held_len] = phsc_pkg::value_t'(weight);
					prefix_mem[held_len + 1] = phsc_pkg::value_t'(
						(wide_t'(prefix_mem[held_len]) + mod_mul(sv, weight)) % MODL);
					weight = mod_mul(weight, cur_base);
					held_len++;
				end
			end
			phsc_pkg::OP_QUERY: begin
				if (a > b || c > d || b >= held_len || d >= held_len) begin
					r.st = phsc_pkg::STATUS_BAD_RANGE;
				end else begin
					h1 = (MODL + prefix_mem[b + 1] - prefix_mem[a]) % MODL;
					h2 = (MODL + prefix_mem[d + 1] - prefix_mem[c]) % MODL;
					r.v1 = phsc_pkg::value_t'(mod_mul(power_mem[c], h1));
					r.v2 = phsc_pkg::value_t'(mod_mul(power_mem[a], h2));
					r.eq = ((b - a) == (d - c)) && (r.v1 == r.v2);
				end
			end
			phsc_pkg::OP_CLEAR: begin
				held_len = 0;
				weight = 1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, wide_t got, wide_t want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	task automatic send_txn(hash_txn_t t, bit typed, logic [phsc_pkg::STATUS_W-1:0] typed_st);
		hash_reply_t r;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		op = t.op;
		symbol = t.sym;
		first_start = t.fs;
		first_end = t.fe;
		second_start = t.ss;
		second_end = t.se;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		r = compute_hash_reply(t);
		n_items++;
		if (r.eq)
			n_equal++;
		if (r.st == phsc_pkg::STATUS_BAD_RANGE)
			n_bad++;
		if (r.st == phsc_pkg::STATUS_FULL)
			n_full++;
		if (typed) begin
			r.v1 = '0;
			r.v2 = '0;
			r.eq = 1'b0;
			r.st = typed_st;
		end
		pending_replies.push_back(r);
		burst_left--;
	endtask

	task automatic drain_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_hash_base(phsc_pkg::value_t v);
		drain_replies();
		@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_write_data = v;
		@(negedge clk);
		cfg_write_en = 1'b0;
		cur_base = wide_t'(v);
		n_bases++;
	endtask

	task automatic add_row(logic [phsc_pkg::OP_W-1:0] o, logic [phsc_pkg::SYMBOL_W-1:0] s,
		int a, int b, int c, int d, bit typed, logic [phsc_pkg::STATUS_W-1:0] st);
		table_row_t row;
		row.t.op = o;
		row.t.sym = s;
		row.t.fs = phsc_pkg::INDEX_W'(a);
		row.t.fe = phsc_pkg::INDEX_W'(b);
		row.t.ss = phsc_pkg::INDEX_W'(c);
		row.t.se = phsc_pkg::INDEX_W'(d);
		row.typed = typed;
		row.st = st;
		directed_rows.push_back(row);
	endtask

	function automatic hash_txn_t make_valid_query();
		hash_txn_t t;
		int        len_a;
		int        len_b;
		int        a;
		int        c;
		len_a = ($urandom_range(0, 9) < 6) ? $urandom_range(1, (held_len < 3) ? held_len : 3)
			: $urandom_range(1, held_len);
		len_b = ($urandom_range(0, 3) != 0) ? len_a : $urandom_range(1, held_len);
		a = $urandom_range(0, held_len - len_a);
		c = $urandom_range(0, held_len - len_b);
		t.op = phsc_pkg::OP_QUERY;
		t.sym = 8'($urandom_range(0, 255));
		t.fs = phsc_pkg::INDEX_W'(a);
		t.fe = phsc_pkg::INDEX_W'(a + len_a - 1);
		t.ss = phsc_pkg::INDEX_W'(c);
		t.se = phsc_pkg::INDEX_W'(c + len_b - 1);
		return t;
	endfunction

	task automatic run_random(int count);
		hash_txn_t t;
		int        kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			t.op = 2'($urandom_range(0, 3));
			t.sym = 8'($urandom_range(0, 255));
			t.fs = phsc_pkg::INDEX_W'($urandom_range(0, 1023));
			t.fe = phsc_pkg::INDEX_W'($urandom_range(0, 1023));
			t.ss = phsc_pkg::INDEX_W'($urandom_range(0, 1023));
			t.se = phsc_pkg::INDEX_W'($urandom_range(0, 1023));
			if ((kind < 45 && held_len < 120) || (kind < 80 && held_len == 0)) begin
				t.op = phsc_pkg::OP_APPEND;
				if ($urandom_range(0, 9) < 7)
					t.sym = 8'($urandom_range(97, 98));
			end else if (kind < 80) begin
				t = make_valid_query();
			end else if (kind < 88) begin
				t.op = phsc_pkg::OP_QUERY;
			end else if (kind < 93) begin
				t.op = OP_UNUSED;
			end else if (kind < 96) begin
				t.op = phsc_pkg::OP_CLEAR;
			end
			send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
		end
	endtask

	task automatic run_long();
		hash_txn_t t;
		t.op = phsc_pkg::OP_CLEAR;
		t.sym = '0;
		t.fs = '0;
		t.fe = '0;
		t.ss = '0;
		t.se = '0;
		send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
		t.op = phsc_pkg::OP_APPEND;
		for (int i = 0; i < LONG_LEN; i++) begin
			t.sym = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(97, 99)) : 8'($urandom_range(0, 255));
			send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
		end
		t.op = phsc_pkg::OP_QUERY;
		t.fs = '0;
		t.fe = phsc_pkg::INDEX_W'(LONG_LEN - 1);
		t.ss = '0;
		t.se = phsc_pkg::INDEX_W'(LONG_LEN - 1);
		send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
		t.fe = phsc_pkg::INDEX_W'(LONG_LEN / 2 - 1);
		t.ss = phsc_pkg::INDEX_W'(LONG_LEN / 2);
		send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
		t.fs = phsc_pkg::INDEX_W'(LONG_LEN - 1);
		t.fe = phsc_pkg::INDEX_W'(LONG_LEN - 1);
		t.ss = phsc_pkg::INDEX_W'(LONG_LEN - 2);
		t.se = phsc_pkg::INDEX_W'(LONG_LEN - 2);
		send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
		t.fs = '0;
		t.fe = '0;
		t.ss = phsc_pkg::INDEX_W'(LONG_LEN - 1);
		t.se = phsc_pkg::INDEX_W'(LONG_LEN - 1);
		send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
		for (int i = 0; i < 16; i++)
			send_txn(make_valid_query(), 1'b0, phsc_pkg::STATUS_OK);
		t.op = phsc_pkg::OP_CLEAR;
		send_txn(t, 1'b0, phsc_pkg::STATUS_OK);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("result with nothing pending, status", status, 0);
			end else begin
				want_reply = pending_replies.pop_front();
				n_results++;
				if (first_value !== want_reply.v1)
					report_mismatch("first_value", first_value, want_reply.v1);
				if (second_value !== want_reply.v2)
					report_mismatch("second_value", second_value, want_reply.v2);
				if (equal !== want_reply.eq)
					report_mismatch("equal", equal, want_reply.eq);
				if (status !== want_reply.st)
					report_mismatch("status", status, want_reply.st);
			end
		end
	end

	// receiver stall pattern and long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (pat_left == 0) begin
					stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
					pat_left = $urandom_range(20, 80);
				end
				out_ready = stall_mask[pat_pos];
				pat_pos = (pat_pos + 1) % 8;
				pat_left--;
			end
		end
	end

	initial begin
		prefix_mem[0] = '0;
		weight = 1;
		cur_base = wide_t'(phsc_pkg::BASE_RESET);
		held_len = 0;

		// directed table, reset base
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_BAD_RANGE);
		add_row(OP_UNUSED,           8'd255, 1023, 1023, 1023, 1023, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_CLEAR,  8'd0,   0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_APPEND, 8'd97,  0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_APPEND, 8'd98,  0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_APPEND, 8'd97,  0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_APPEND, 8'd98,  0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_APPEND, 8'd0,   1023, 1023, 1023, 1023, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_APPEND, 8'd255, 0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_APPEND, 8'd96,  0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    1,    2,    3, 1'b0, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    1,    1,    2, 1'b0, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    0,    0,    1, 1'b0, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    6,    0,    6, 1'b0, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   4,    4,    5,    5, 1'b0, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   1,    0,    0,    0, 1'b1, phsc_pkg::STATUS_BAD_RANGE);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    0,    3,    2, 1'b1, phsc_pkg::STATUS_BAD_RANGE);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    7,    0,    0, 1'b1, phsc_pkg::STATUS_BAD_RANGE);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    0,    0, 1023, 1'b1, phsc_pkg::STATUS_BAD_RANGE);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   6,    6,    6,    6, 1'b0, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_CLEAR,  8'd0,   0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_BAD_RANGE);
		add_row(phsc_pkg::OP_APPEND, 8'd122, 0,    0,    0,    0, 1'b1, phsc_pkg::STATUS_OK);
		add_row(phsc_pkg::OP_QUERY,  8'd0,   0,    0,    0,    0, 1'b0, phsc_pkg::STATUS_OK);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_txn(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].st);

		// smallest base, long receiver hold-off while the sender keeps offering
		set_hash_base(30'd2);
		hold_off_req = 1'b1;
		burst_left = 60;
		run_random(110);

		set_hash_base(30'd1000000006);
		run_random(90);

		// base above the modulus
		set_hash_base(30'h3FFF_FFFF);
		run_random(90);

		set_hash_base(phsc_pkg::value_t'($urandom_range(3, 1000000005)));
		run_long();

		set_hash_base(phsc_pkg::BASE_RESET);
		run_random(60);

		drain_replies();
		repeat (30) @(posedge clk);
		if (pending_replies.size() != 0)
			report_mismatch("results never arrived", pending_replies.size(), 0);

		$display("covered %0d transactions, %0d results, %0d hash bases written",
			n_items, n_results, n_bases);
		$display("equal hits %0d, bad ranges %0d, full-store appends %0d, mismatches %0d",
			n_equal, n_bad, n_full, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
